@@ sv/otsr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the overlay tile save/restore unit.
// No dependencies; every other file of the block but otsr_ram imports this package.
package otsr_pkg;

    // Operation codes carried on the opcode field
    localparam int OP_W = 3;
    typedef enum logic [OP_W-1:0] {
        OP_RESET_ALL    = 3'd0,
        OP_BASE_REBUILT = 3'd1,
        OP_BEGIN_FRAME  = 3'd2,
        OP_FINISH_FRAME = 3'd3,
        OP_MARK_TILE    = 3'd4,
        OP_RESTORE_TILE = 3'd5
    } t_opcode;

    // Field widths fixed by the item format
    localparam int TILE_W = 9;
    localparam int WORD_W = 64;

    // A snapshot is four 64-bit words moved one word per beat
    localparam int WORDS_PER_SNAP        = 4;
    localparam int BEAT_W                = 2;
    localparam logic [BEAT_W-1:0] BEAT_LAST = BEAT_W'(WORDS_PER_SNAP - 1);

    typedef logic [WORD_W-1:0] t_word;

    // Bit positions inside one tile-state entry: {slot, valid, cur, prev}
    localparam int ENT_PREV     = 0;
    localparam int ENT_CUR      = 1;
    localparam int ENT_VALID    = 2;
    localparam int ENT_SLOT_LSB = 3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic dispatch;
        logic look;
        logic save_beat;
        logic load_beat;
        logic init_write;
        logic sweep_read;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            in_range;
        logic            start_save;
        logic            restore_hit;
        logic            sweep_last;
        logic            beat_last;
        logic            out_free;
    } t_dp_status;

endpackage

@@ sv/otsr_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module otsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and read; a read at the address being written returns old data
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/otsr_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer of the overlay tile save/restore unit.
// Depends on otsr_pkg for the command and status structs and opcodes.
module otsr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  otsr_pkg::t_dp_status i_status,
    output otsr_pkg::t_dp_cmd    o_cmd
);
    import otsr_pkg::*;

    typedef enum logic [8:0] {
        S_INIT     = 9'b0_0000_0001,
        S_IDLE     = 9'b0_0000_0010,
        S_DISPATCH = 9'b0_0000_0100,
        S_LOOK     = 9'b0_0000_1000,
        S_SAVE     = 9'b0_0001_0000,
        S_LOAD     = 9'b0_0010_0000,
        S_TAIL     = 9'b0_0100_0000,
        S_SWEEP    = 9'b0_1000_0000,
        S_DONE     = 9'b1_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Decode next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_INIT: begin
                o_cmd.init_write = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.capture = i_valid;
                if (i_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                o_cmd.dispatch = 1'b1;
                if (i_status.op inside {OP_RESET_ALL, OP_BASE_REBUILT,
                                        OP_BEGIN_FRAME, OP_FINISH_FRAME}) begin
                    n_state = S_SWEEP;
                end else if ((i_status.op inside {OP_MARK_TILE, OP_RESTORE_TILE})
                             && i_status.in_range) begin
                    n_state = S_LOOK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                if (i_status.start_save) begin
                    n_state = S_SAVE;
                end else if (i_status.restore_hit) begin
                    n_state = S_LOAD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SAVE: begin
                o_cmd.save_beat = 1'b1;
                if (i_status.beat_last) begin
                    n_state = S_DONE;
                end
            end
            S_LOAD: begin
                o_cmd.load_beat = 1'b1;
                if (i_status.beat_last) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = S_DONE;
            end
            S_SWEEP: begin
                o_cmd.sweep_read = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // Advance state; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/otsr_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the overlay tile save/restore unit: tile-state RAM, snapshot RAM,
// slot allocator, sweep counter and output register. Depends on otsr_pkg, otsr_ram.
module otsr_datapath #(
    parameter int TILE_COUNT     = 512,
    parameter int SNAPSHOT_SLOTS = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  otsr_pkg::t_dp_cmd           i_cmd,
    output otsr_pkg::t_dp_status        o_status,
    input  logic [otsr_pkg::OP_W-1:0]   i_opcode,
    input  logic [otsr_pkg::TILE_W-1:0] i_tile_index,
    input  logic [otsr_pkg::WORD_W-1:0] i_rows_01,
    input  logic [otsr_pkg::WORD_W-1:0] i_rows_23,
    input  logic [otsr_pkg::WORD_W-1:0] i_rows_45,
    input  logic [otsr_pkg::WORD_W-1:0] i_rows_67,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [otsr_pkg::TILE_W-1:0] o_out_tile,
    output logic                        o_write_back,
    output logic                        o_mark_dirty,
    output logic [otsr_pkg::WORD_W-1:0] o_saved_01,
    output logic [otsr_pkg::WORD_W-1:0] o_saved_23,
    output logic [otsr_pkg::WORD_W-1:0] o_saved_45,
    output logic [otsr_pkg::WORD_W-1:0] o_saved_67,
    output logic                        o_needs_rebuild
);
    import otsr_pkg::*;

    localparam int TAW   = $clog2(TILE_COUNT);
    localparam int SW    = (SNAPSHOT_SLOTS > 1) ? $clog2(SNAPSHOT_SLOTS) : 1;
    localparam int UW    = $clog2(SNAPSHOT_SLOTS + 1);
    localparam int SDEP  = SNAPSHOT_SLOTS * WORDS_PER_SNAP;
    localparam int SAW   = $clog2(SDEP);
    localparam int EW    = ENT_SLOT_LSB + SW;
    localparam int XW    = TAW + TILE_W;

    // Item registers
    logic [OP_W-1:0]   r_op;
    logic [TILE_W-1:0] r_tile;
    t_word             r_rows [WORDS_PER_SNAP];

    // Control registers
    logic [UW-1:0]     r_slots_used;
    logic              r_overflow;
    logic [TAW-1:0]    r_sweep;
    logic [TAW-1:0]    r_sw_addr;
    logic              r_sw_wen;
    logic [BEAT_W-1:0] r_beat;
    logic [BEAT_W-1:0] r_cap_beat;
    logic              r_cap_en;
    logic [SW-1:0]     r_slot;

    // Pending result
    logic              r_res_wb;
    logic              r_res_dirty;
    t_word             r_res_saved [WORDS_PER_SNAP];

    // Output register
    logic              r_valid;
    logic [TILE_W-1:0] r_out_tile;
    logic              r_out_wb;
    logic              r_out_dirty;
    t_word             r_out_saved [WORDS_PER_SNAP];
    logic              r_out_rebuild;

    // RAM ports
    logic              t_we;
    logic [TAW-1:0]    t_waddr;
    logic [EW-1:0]     t_wdata;
    logic [TAW-1:0]    t_raddr;
    logic [EW-1:0]     t_rdata;
    logic [SW+1:0]     s_addr_full;
    logic [SAW-1:0]    s_addr;
    t_word             s_rdata;

    // Decode of the registered item and of the looked-up entry
    logic [XW-1:0]     tile_ext;
    logic [TAW-1:0]    tile_addr;
    logic              in_range;
    logic              is_mark;
    logic              is_restore;
    logic              e_prev;
    logic              e_cur;
    logic              e_valid;
    logic [SW-1:0]     e_slot;
    logic              full;
    logic [SW-1:0]     alloc_slot;
    logic              mark_new;
    logic              alloc;
    logic              ovf_set;
    logic              restore_hit;
    logic [EW-1:0]     look_entry;
    logic [EW-1:0]     sweep_entry;

    assign tile_ext   = {TAW'(0), r_tile};
    assign tile_addr  = tile_ext[TAW-1:0];
    assign in_range   = tile_ext < XW'(TILE_COUNT);
    assign is_mark    = (r_op == OP_MARK_TILE);
    assign is_restore = (r_op == OP_RESTORE_TILE);

    assign e_prev     = t_rdata[ENT_PREV];
    assign e_cur      = t_rdata[ENT_CUR];
    assign e_valid    = t_rdata[ENT_VALID];
    assign e_slot     = t_rdata[EW-1:ENT_SLOT_LSB];

    assign full        = r_slots_used >= UW'(SNAPSHOT_SLOTS);
    assign alloc_slot  = r_slots_used[SW-1:0];
    assign mark_new    = is_mark && !e_cur;
    assign alloc       = mark_new && !e_valid && !full;
    assign ovf_set     = mark_new && !e_valid && full;
    assign restore_hit = is_restore && e_prev && e_valid;

    assign look_entry = {alloc ? alloc_slot : e_slot, e_valid | alloc, 1'b1, e_prev};

    // Per-entry rewrite for the frame and reset operations
    always_comb begin
        sweep_entry = t_rdata;
        case (r_op)
            OP_RESET_ALL: begin
                sweep_entry[ENT_PREV]  = 1'b0;
                sweep_entry[ENT_CUR]   = 1'b0;
                sweep_entry[ENT_VALID] = 1'b0;
            end
            OP_BASE_REBUILT: begin
                sweep_entry[ENT_PREV]  = 1'b0;
                sweep_entry[ENT_VALID] = 1'b0;
            end
            OP_BEGIN_FRAME: begin
                sweep_entry[ENT_CUR] = 1'b0;
            end
            OP_FINISH_FRAME: begin
                sweep_entry[ENT_PREV] = t_rdata[ENT_CUR];
            end
            default: begin
                sweep_entry = t_rdata;
            end
        endcase
    end

    // Select the tile-state write: clearing pass, sweep write-back, or mark update
    always_comb begin
        t_we    = 1'b0;
        t_waddr = r_sweep;
        t_wdata = '0;
        if (i_cmd.init_write) begin
            t_we = 1'b1;
        end else if (r_sw_wen) begin
            t_we    = 1'b1;
            t_waddr = r_sw_addr;
            t_wdata = sweep_entry;
        end else if (i_cmd.look && mark_new) begin
            t_we    = 1'b1;
            t_waddr = tile_addr;
            t_wdata = look_entry;
        end
    end

    assign t_raddr = i_cmd.sweep_read ? r_sweep : tile_addr;

    otsr_ram #(
        .WIDTH (EW),
        .DEPTH (TILE_COUNT)
    ) u_tile_ram (
        .i_clk     (i_clk),
        .i_wr_en   (t_we),
        .i_wr_addr (t_waddr),
        .i_wr_data (t_wdata),
        .i_rd_addr (t_raddr),
        .o_rd_data (t_rdata)
    );

    // Snapshot word address: slot in the high bits, beat in the low bits
    assign s_addr_full = {r_slot, r_beat};
    assign s_addr      = s_addr_full[SAW-1:0];

    otsr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SDEP)
    ) u_snap_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.save_beat),
        .i_wr_addr (s_addr),
        .i_wr_data (r_rows[r_beat]),
        .i_rd_addr (s_addr),
        .o_rd_data (s_rdata)
    );

    // Control state: allocator, overflow, counters, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_used <= '0;
            r_overflow   <= 1'b0;
            r_sweep      <= '0;
            r_sw_wen     <= 1'b0;
            r_beat       <= '0;
            r_cap_en     <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            if (i_cmd.dispatch && (r_op == OP_RESET_ALL || r_op == OP_BASE_REBUILT)) begin
                r_slots_used <= '0;
                r_overflow   <= 1'b0;
            end else if (i_cmd.look) begin
                if (alloc) begin
                    r_slots_used <= r_slots_used + 1'b1;
                end
                if (ovf_set) begin
                    r_overflow <= 1'b1;
                end
            end

            if (i_cmd.dispatch) begin
                r_sweep <= '0;
            end else if (i_cmd.init_write || i_cmd.sweep_read) begin
                r_sweep <= r_sweep + 1'b1;
            end
            r_sw_wen <= i_cmd.sweep_read;

            if (i_cmd.look) begin
                r_beat <= '0;
            end else if (i_cmd.save_beat || i_cmd.load_beat) begin
                r_beat <= r_beat + 1'b1;
            end
            r_cap_en <= i_cmd.load_beat;

            if (i_cmd.out_load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload: capture item, build result, load output register
    always_ff @(posedge i_clk) begin
        r_sw_addr  <= r_sweep;
        r_cap_beat <= r_beat;

        if (i_cmd.capture) begin
            r_op        <= i_opcode;
            r_tile      <= i_tile_index;
            r_rows[0]   <= i_rows_01;
            r_rows[1]   <= i_rows_23;
            r_rows[2]   <= i_rows_45;
            r_rows[3]   <= i_rows_67;
            r_res_wb    <= 1'b0;
            r_res_dirty <= 1'b0;
            for (int k = 0; k < WORDS_PER_SNAP; k++) begin
                r_res_saved[k] <= '0;
            end
        end

        if (i_cmd.look) begin
            r_res_dirty <= mark_new || restore_hit;
            r_res_wb    <= restore_hit;
            r_slot      <= alloc ? alloc_slot : e_slot;
        end

        if (r_cap_en) begin
            r_res_saved[r_cap_beat] <= s_rdata;
        end

        if (i_cmd.out_load) begin
            r_out_tile    <= (is_mark || is_restore) ? r_tile : '0;
            r_out_wb      <= r_res_wb;
            r_out_dirty   <= r_res_dirty;
            r_out_rebuild <= r_overflow;
            for (int k = 0; k < WORDS_PER_SNAP; k++) begin
                r_out_saved[k] <= r_res_saved[k];
            end
        end
    end

    // Status to the controller
    assign o_status.op          = r_op;
    assign o_status.in_range    = in_range;
    assign o_status.start_save  = alloc;
    assign o_status.restore_hit = restore_hit;
    assign o_status.sweep_last  = (r_sweep == TAW'(TILE_COUNT - 1));
    assign o_status.beat_last   = (r_beat == BEAT_LAST);
    assign o_status.out_free    = !r_valid || !i_stall;

    assign o_valid         = r_valid;
    assign o_out_tile      = r_out_tile;
    assign o_write_back    = r_out_wb;
    assign o_mark_dirty    = r_out_dirty;
    assign o_saved_01      = r_out_saved[0];
    assign o_saved_23      = r_out_saved[1];
    assign o_saved_45      = r_out_saved[2];
    assign o_saved_67      = r_out_saved[3];
    assign o_needs_rebuild = r_out_rebuild;

endmodule

@@ sv/overlay_tile_save_restore_unit.sv @@
`timescale 1ns / 1ps
// Overlay tile save-under cache: top level joining controller and datapath.
// Depends on otsr_pkg, otsr_ctrl, otsr_datapath (and otsr_ram below it).
//
// Input channel: i_valid / o_stall carry one operation (opcode, tile index and
// four 64-bit row words). Output channel: o_valid / i_stall carry exactly one
// result per operation. A transfer happens on a clock edge with valid high and
// stall low.
// Items are handled one at a time: no new input is taken until the result of the
// last one is in the output register. An out-of-range or unused operation goes
// straight to its result; a mark or restore first looks up the tile-state RAM; a
// mark that saves a snapshot then makes four writes into the 64-bit snapshot RAM,
// and a restore hit four reads from that RAM through its registered read; and
// reset_all, base_rebuilt, begin_frame and finish_frame sweep the tile-state RAM
// one entry per cycle.
// A result waiting on a stalled receiver does not block the next input; the
// block only waits before loading the following result.
// After i_rst_n is released a clearing pass zeroes the tile-state RAM; o_stall
// stays high until it completes.
module overlay_tile_save_restore_unit #(
    parameter int TILE_COUNT     = 512,
    parameter int SNAPSHOT_SLOTS = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [otsr_pkg::OP_W-1:0]   i_opcode,
    input  logic [otsr_pkg::TILE_W-1:0] i_tile_index,
    input  logic [otsr_pkg::WORD_W-1:0] i_rows_01,
    input  logic [otsr_pkg::WORD_W-1:0] i_rows_23,
    input  logic [otsr_pkg::WORD_W-1:0] i_rows_45,
    input  logic [otsr_pkg::WORD_W-1:0] i_rows_67,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [otsr_pkg::TILE_W-1:0] o_out_tile,
    output logic                        o_write_back,
    output logic                        o_mark_dirty,
    output logic [otsr_pkg::WORD_W-1:0] o_saved_01,
    output logic [otsr_pkg::WORD_W-1:0] o_saved_23,
    output logic [otsr_pkg::WORD_W-1:0] o_saved_45,
    output logic [otsr_pkg::WORD_W-1:0] o_saved_67,
    output logic                        o_needs_rebuild
);
    import otsr_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequence each operation
    otsr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Hold state, snapshots and the result
    otsr_datapath #(
        .TILE_COUNT     (TILE_COUNT),
        .SNAPSHOT_SLOTS (SNAPSHOT_SLOTS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_opcode        (i_opcode),
        .i_tile_index    (i_tile_index),
        .i_rows_01       (i_rows_01),
        .i_rows_23       (i_rows_23),
        .i_rows_45       (i_rows_45),
        .i_rows_67       (i_rows_67),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_out_tile      (o_out_tile),
        .o_write_back    (o_write_back),
        .o_mark_dirty    (o_mark_dirty),
        .o_saved_01      (o_saved_01),
        .o_saved_23      (o_saved_23),
        .o_saved_45      (o_saved_45),
        .o_saved_67      (o_saved_67),
        .o_needs_rebuild (o_needs_rebuild)
    );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for overlay_tile_save_restore_unit: drives marks, restores and
// frame operations, predicts every result in-line and compares it field by field.
// Depends on otsr_pkg and the RTL under sv/.
module tb;
    import otsr_pkg::*;

    localparam int TILES       = 512;
    localparam int SLOTS       = 128;
    localparam int ITEMS       = 950;
    localparam int QUIET_LIMIT = 4000;
    localparam int CALM_FIRST  = 300;
    localparam int CALM_LAST   = 450;

    // Opcodes the block does not define; it answers them with only the overflow flag
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]                    op;
        logic [TILE_W-1:0]                  tile;
        logic [WORDS_PER_SNAP-1:0][WORD_W-1:0] rows;
        logic                               wait_drain;
    } t_tile_op;

    typedef struct packed {
        logic [TILE_W-1:0]                  tile;
        logic                               write_back;
        logic                               mark_dirty;
        logic [WORDS_PER_SNAP-1:0][WORD_W-1:0] saved;
        logic                               needs_rebuild;
    } t_tile_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [OP_W-1:0]   i_opcode;
    logic [TILE_W-1:0] i_tile_index;
    logic [WORD_W-1:0] i_rows_01, i_rows_23, i_rows_45, i_rows_67;
    logic              o_valid;
    logic              i_stall;
    logic [TILE_W-1:0] o_out_tile;
    logic              o_write_back;
    logic              o_mark_dirty;
    logic [WORD_W-1:0] o_saved_01, o_saved_23, o_saved_45, o_saved_67;
    logic              o_needs_rebuild;

    overlay_tile_save_restore_unit #(
        .TILE_COUNT     (TILES),
        .SNAPSHOT_SLOTS (SLOTS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_tile_index    (i_tile_index),
        .i_rows_01       (i_rows_01),
        .i_rows_23       (i_rows_23),
        .i_rows_45       (i_rows_45),
        .i_rows_67       (i_rows_67),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_tile      (o_out_tile),
        .o_write_back    (o_write_back),
        .o_mark_dirty    (o_mark_dirty),
        .o_saved_01      (o_saved_01),
        .o_saved_23      (o_saved_23),
        .o_saved_45      (o_saved_45),
        .o_saved_67      (o_saved_67),
        .o_needs_rebuild (o_needs_rebuild)
    );

    always #5 i_clk = ~i_clk;

    // Stimulus, expected results and bookkeeping
    t_tile_op     tile_ops_pending[$];
    t_tile_result awaited_results[$];
    t_tile_op     op_in_flight;
    int           items_sent   = 0;
    int           results_seen = 0;
    int           fail_count   = 0;
    int           quiet_cycles = 0;
    bit           calm         = 1'b0;

    // Shadow of the cache state
    logic [TILES-1:0] prev_map, cur_map, slot_owned;
    logic [6:0]       slot_of_tile [TILES];
    logic [WORDS_PER_SNAP-1:0][WORD_W-1:0] snap_store [SLOTS];
    int               slots_taken;
    logic             overflow;

    // Apply one operation to the shadow state and return the result it causes
    function automatic t_tile_result apply_tile_op(input t_tile_op item);
        t_tile_result r;
        int           t;
        r = '0;
        t = int'(item.tile);
        case (item.op)
            OP_RESET_ALL: begin
                prev_map    = '0;
                cur_map     = '0;
                slot_owned  = '0;
                slots_taken = 0;
                overflow    = 1'b0;
            end
            OP_BASE_REBUILT: begin
                prev_map    = '0;
                slot_owned  = '0;
                slots_taken = 0;
                overflow    = 1'b0;
            end
            OP_BEGIN_FRAME:  cur_map  = '0;
            OP_FINISH_FRAME: prev_map = cur_map;
            OP_MARK_TILE: begin
                r.tile = item.tile;
                if (t < TILES && !cur_map[t]) begin
                    if (!slot_owned[t]) begin
                        if (slots_taken >= SLOTS) begin
                            overflow = 1'b1;
                        end else begin
                            slot_of_tile[t]        = slots_taken[6:0];
                            slot_owned[t]          = 1'b1;
                            snap_store[slots_taken] = item.rows;
                            slots_taken++;
                        end
                    end
                    cur_map[t]   = 1'b1;
                    r.mark_dirty = 1'b1;
                end
            end
            OP_RESTORE_TILE: begin
                r.tile = item.tile;
                if (t < TILES && prev_map[t] && slot_owned[t]) begin
                    r.saved      = snap_store[slot_of_tile[t]];
                    r.write_back = 1'b1;
                    r.mark_dirty = 1'b1;
                end
            end
            default: ;
        endcase
        r.needs_rebuild = overflow;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
            fail_count++;
        end
    endtask

    function automatic logic [WORD_W-1:0] rnd_word();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_op(input logic [OP_W-1:0] op, input int tile,
                            input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1,
                            input logic [WORD_W-1:0] w2, input logic [WORD_W-1:0] w3,
                            input int wait_drain);
        t_tile_op item;
        item.op         = op;
        item.tile       = tile[TILE_W-1:0];
        item.rows       = {w3, w2, w1, w0};
        item.wait_drain = (wait_drain != 0);
        tile_ops_pending.push_back(item);
    endtask

    // Driver: present the next pending operation, hold it until the transfer
    always @(posedge i_clk) begin : drive_ops
        logic     next_valid;
        int       sent_now;
        t_tile_op nxt;
        if (!i_rst_n) begin
            i_valid      <= 1'b0;
            i_opcode     <= OP_RESET_ALL;
            i_tile_index <= '0;
            i_rows_01    <= '0;
            i_rows_23    <= '0;
            i_rows_45    <= '0;
            i_rows_67    <= '0;
            op_in_flight <= '0;
        end else begin
            next_valid = i_valid;
            sent_now   = items_sent;
            if (i_valid && !o_stall) begin
                awaited_results.push_back(apply_tile_op(op_in_flight));
                sent_now   = items_sent + 1;
                next_valid = 1'b0;
            end
            if (!next_valid && tile_ops_pending.size() > 0
                && (calm || $urandom_range(99) >= 9)
                && (!tile_ops_pending[0].wait_drain || results_seen == sent_now)) begin
                nxt          = tile_ops_pending.pop_front();
                op_in_flight <= nxt;
                i_opcode     <= nxt.op;
                i_tile_index <= nxt.tile;
                i_rows_01    <= nxt.rows[0];
                i_rows_23    <= nxt.rows[1];
                i_rows_45    <= nxt.rows[2];
                i_rows_67    <= nxt.rows[3];
                next_valid   = 1'b1;
            end
            i_valid    <= next_valid;
            items_sent <= sent_now;
            calm       <= (sent_now >= CALM_FIRST && sent_now < CALM_LAST);
        end
    end

    // Monitor: compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin : watch_results
        t_tile_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result for tile %0d with no operation outstanding",
                             $time, o_out_tile);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("out_tile", WORD_W'(want.tile), WORD_W'(o_out_tile));
                    check_field("write_back", WORD_W'(want.write_back),
                                WORD_W'(o_write_back));
                    check_field("mark_dirty", WORD_W'(want.mark_dirty),
                                WORD_W'(o_mark_dirty));
                    check_field("saved_01", want.saved[0], o_saved_01);
                    check_field("saved_23", want.saved[1], o_saved_23);
                    check_field("saved_45", want.saved[2], o_saved_45);
                    check_field("saved_67", want.saved[3], o_saved_67);
                    check_field("needs_rebuild", WORD_W'(want.needs_rebuild),
                                WORD_W'(o_needs_rebuild));
                end
                results_seen <= results_seen + 1;
            end
            i_stall <= !calm && ($urandom_range(99) < 9);
        end
    end

    // Watchdog: give up after a long run of cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("overlay_tile_save_restore_unit regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int marked_now[$];
        int marked_last[$];
        int roll, n, base, t, bursts;
        logic [WORD_W-1:0] ones, alt, fives;
        ones   = '1;
        alt    = {4{16'hAAAA}};
        fives  = {4{16'h5A5A}};
        bursts = 0;

        i_rst_n      = 1'b0;

        // Directed: extremes, repeat marks, hits and misses, spare opcodes, rebuilds
        queue_op(OP_RESET_ALL,    0,   '0, '0, '0, '0, 0);
        queue_op(OP_MARK_TILE,    0,   ones, ones, ones, ones, 0);
        queue_op(OP_MARK_TILE,    511, '0, '0, '0, '0, 0);
        queue_op(OP_MARK_TILE,    0,   alt, alt, alt, alt, 0);
        queue_op(OP_RESTORE_TILE, 0,   '0, '0, '0, '0, 0);
        queue_op(OP_FINISH_FRAME, 0,   '0, '0, '0, '0, 0);
        queue_op(OP_RESTORE_TILE, 0,   '0, '0, '0, '0, 0);
        queue_op(OP_RESTORE_TILE, 511, ones, ones, ones, ones, 0);
        queue_op(OP_RESTORE_TILE, 5,   '0, '0, '0, '0, 0);
        queue_op(OP_BEGIN_FRAME,  0,   '0, '0, '0, '0, 0);
        queue_op(OP_RESTORE_TILE, 0,   '0, '0, '0, '0, 0);
        queue_op(OP_MARK_TILE,    0,   alt, alt, alt, alt, 0);
        queue_op(OP_FINISH_FRAME, 0,   '0, '0, '0, '0, 0);
        queue_op(OP_RESTORE_TILE, 0,   '0, '0, '0, '0, 0);
        queue_op(OP_SPARE_6,      511, ones, ones, ones, ones, 0);
        queue_op(OP_SPARE_7,      0,   '0, '0, '0, '0, 0);
        queue_op(OP_BASE_REBUILT, 0,   '0, '0, '0, '0, 0);
        queue_op(OP_RESTORE_TILE, 0,   '0, '0, '0, '0, 0);
        queue_op(OP_MARK_TILE,    0,   ones, ones, ones, ones, 0);
        queue_op(OP_BEGIN_FRAME,  0,   '0, '0, '0, '0, 0);
        queue_op(OP_MARK_TILE,    0,   fives, alt, fives, alt, 0);
        queue_op(OP_FINISH_FRAME, 0,   '0, '0, '0, '0, 0);
        queue_op(OP_RESTORE_TILE, 0,   '0, '0, '0, '0, 0);
        queue_op(OP_RESET_ALL,    0,   '0, '0, '0, '0, 0);
        queue_op(OP_RESTORE_TILE, 0,   '0, '0, '0, '0, 0);

        // Random: mostly well-formed frames, some slot-exhausting bursts, some noise
        while (tile_ops_pending.size() < ITEMS) begin
            roll = (bursts == 0) ? 10 : $urandom_range(99);
            if (roll < 4) begin
                queue_op(OP_RESET_ALL, $urandom_range(511),
                         rnd_word(), rnd_word(), rnd_word(), rnd_word(), 0);
                marked_now.delete();
                marked_last.delete();
            end else if (roll < 7) begin
                queue_op(OP_BASE_REBUILT, $urandom_range(511),
                         rnd_word(), rnd_word(), rnd_word(), rnd_word(), 0);
                marked_last.delete();
            end else if (roll < 12 && bursts < 2) begin
                // Mark more distinct tiles than there are slots; the first burst
                // waits for the block to drain before it starts
                queue_op(OP_RESET_ALL, 0, '0, '0, '0, '0, int'(bursts == 0));
                queue_op(OP_BEGIN_FRAME, 0, '0, '0, '0, '0, 0);
                marked_now.delete();
                base = $urandom_range(511);
                n    = SLOTS + $urandom_range(2, 12);
                for (int k = 0; k < n; k++) begin
                    t = (base + k) % TILES;
                    queue_op(OP_MARK_TILE, t,
                             rnd_word(), rnd_word(), rnd_word(), rnd_word(), 0);
                    marked_now.push_back(t);
                end
                queue_op(OP_FINISH_FRAME, 0, '0, '0, '0, '0, 0);
                marked_last = marked_now;
                for (int k = 0; k < 8; k++) begin
                    t = marked_last[$urandom_range(marked_last.size() - 1)];
                    queue_op(OP_RESTORE_TILE, t,
                             rnd_word(), rnd_word(), rnd_word(), rnd_word(), 0);
                end
                bursts++;
            end else if (roll < 17) begin
                // Noise: any opcode, any tile
                n = $urandom_range(3, 8);
                for (int k = 0; k < n; k++)
                    queue_op(OP_W'($urandom_range(7)), $urandom_range(511),
                             rnd_word(), rnd_word(), rnd_word(), rnd_word(), 0);
            end else begin
                // One frame: begin, marks with some repeats, finish, restores
                queue_op(OP_BEGIN_FRAME, $urandom_range(511),
                         rnd_word(), rnd_word(), rnd_word(), rnd_word(), 0);
                marked_now.delete();
                n = $urandom_range(4, 24);
                for (int k = 0; k < n; k++) begin
                    if (marked_now.size() > 0 && $urandom_range(99) < 20)
                        t = marked_now[$urandom_range(marked_now.size() - 1)];
                    else
                        t = $urandom_range(511);
                    queue_op(OP_MARK_TILE, t,
                             rnd_word(), rnd_word(), rnd_word(), rnd_word(), 0);
                    marked_now.push_back(t);
                end
                queue_op(OP_FINISH_FRAME, $urandom_range(511),
                         rnd_word(), rnd_word(), rnd_word(), rnd_word(), 0);
                marked_last = marked_now;
                n = $urandom_range(4, 20);
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(99) < 75)
                        t = marked_last[$urandom_range(marked_last.size() - 1)];
                    else
                        t = $urandom_range(511);
                    queue_op(OP_RESTORE_TILE, t,
                             rnd_word(), rnd_word(), rnd_word(), rnd_word(), 0);
                end
            end
        end

        // Hold reset, then release it once
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every transfer and every result, then let the block settle
        while (!(tile_ops_pending.size() == 0 && !i_valid && results_seen == items_sent))
            @(negedge i_clk);
        repeat (TILES + 8) @(negedge i_clk);

        if (fail_count == 0)
            $display("overlay_tile_save_restore_unit regression: pass");
        else
            $display("overlay_tile_save_restore_unit regression: fail");
        $finish;
    end

endmodule
